// ===== hdl/tap_tempo_bpm_averager_macros.svh =====
// Assertion macros for the tap tempo averager checker.
// No dependencies; included by the checker file.
`ifndef TAP_TEMPO_BPM_AVERAGER_MACROS_SVH
`define TAP_TEMPO_BPM_AVERAGER_MACROS_SVH

// same-cycle implication
`define TTBA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tap tempo check failed");

// next-cycle implication
`define TTBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tap tempo check failed");

`endif

// ===== hdl/ttba_pkg.sv =====
// Types and constants for the tap tempo averager.
// No dependencies; used by tap_tempo_bpm_averager.
package ttba_pkg;

   localparam int DIV_W = 24;
   localparam int RATE_W = 16;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [DIV_W-1:0] TEMPO_NUM_Q8 = 24'd15360000;
   localparam logic [RATE_W-1:0] MAX_INTERVAL_RST = 16'd2000;
   localparam logic [7:0] MAX_BPM_RST = 8'd240;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BPM = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TEMPO,
      ST_UPDATE,
      ST_DIV_MEAN,
      ST_DONE
   } ttba_state_type;

endpackage

// ===== hdl/tap_tempo_bpm_averager.sv =====
// Accepted tap: divide for the tempo, update the window, divide for the mean, then load
// the result register once the output is not stalled; req_stall stays high until idle.
// One bit-serial restoring divider runs 24 steps for 60000*256/interval and S steps for
// the window mean, S = 16 + clog2(WINDOW_LEN). Ignored taps give no result.
// Synchronous active-high reset clears the window, the running sum, the result
// valid flag and loads the register defaults (max interval 2000, max BPM 240).
module tap_tempo_bpm_averager #(
   parameter int WINDOW_LEN = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_interval_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [15:0]                         rsp_bpm_estimate,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ttba_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ttba_pkg::*;

   localparam int SUM_W = RATE_W + $clog2(WINDOW_LEN);

   ttba_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [RATE_W-1:0] win_ff [WINDOW_LEN];
   logic              win_shift;
   logic [RATE_W-1:0] tempo;
   logic [RATE_W-1:0] limit;
   logic [15:0]       max_int_ff;
   logic [7:0]        max_bpm_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_load;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;
   logic              ge;
   logic [RATE_W-1:0] rem_step;
   logic [DIV_W-1:0]  quo_step;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bpm_estimate = rsp_data_ff;

   assign limit = {max_bpm_ff, 8'd0};
   assign tempo = (quo_ff > {8'd0, limit}) ? limit : quo_ff[RATE_W-1:0];

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff = trial - {1'b0, dvs_ff};
   assign ge = (trial >= {1'b0, dvs_ff});
   assign rem_step = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
   assign quo_step = {quo_ff[DIV_W-2:0], ge};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      sum_in = sum_ff;
      win_shift = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_interval_ms <= max_int_ff)) begin
               quo_in = TEMPO_NUM_Q8;
               rem_in = '0;
               dvs_in = req_interval_ms;
               cnt_in = CNT_W'(DIV_W);
               state_in = ST_DIV_TEMPO;
            end
         end
         ST_DIV_TEMPO: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            win_shift = 1'b1;
            sum_in = sum_ff - SUM_W'(win_ff[0]) + SUM_W'(tempo);
            quo_in = {sum_in, {(DIV_W - SUM_W){1'b0}}};
            rem_in = '0;
            dvs_in = RATE_W'(WINDOW_LEN);
            cnt_in = CNT_W'(SUM_W);
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = quo_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff <= '0;
         max_int_ff <= MAX_INTERVAL_RST;
         max_bpm_ff <= MAX_BPM_RST;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff <= sum_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_INTERVAL: max_int_ff <= csr_wdata;
               CSR_MAX_BPM:      max_bpm_ff <= csr_wdata[7:0];
               default:          ;
            endcase
         end
         if (win_shift) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[WINDOW_LEN-1] <= tempo;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/ttba_chk.sv =====
// Port-level checks for the tap tempo averager, bound to its top level.
// Depends on tap_tempo_bpm_averager_macros.svh.
`include "tap_tempo_bpm_averager_macros.svh"

module ttba_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_bpm_estimate
);

   `TTBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bpm_estimate))
   `TTBA_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, rsp_bpm_estimate <= 16'd65280)
   `TTBA_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))
   `TTBA_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind tap_tempo_bpm_averager ttba_chk u_ttba_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bpm_estimate (rsp_bpm_estimate)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tap tempo BPM averager: directed and random taps
// against an in-bench window-mean predictor. Depends on ttba_pkg and the RTL top.
module testbench;
   import ttba_pkg::*;

   localparam logic [31:0] BEAT_MS_Q8 = 32'd15360000;
   localparam int WINDOW_DEPTH = 8;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT = 5000;
   localparam int RSP_HOLD_CYCLES = 700;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 8'hFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_interval_ms = 16'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_bpm_estimate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [15:0] max_interval_cfg = MAX_INTERVAL_RST;
   logic [7:0] max_bpm_cfg = MAX_BPM_RST;
   logic [15:0] tempo_hist [WINDOW_DEPTH];
   logic [15:0] pending_bpm_q [$];
   logic [15:0] bpm_want;
   bit idle_enable = 1'b1;
   bit rsp_hold_req = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int hold_count;

   tap_tempo_bpm_averager u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_interval_ms  (req_interval_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bpm_estimate (rsp_bpm_estimate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] tap_tempo_q8(input logic [15:0] interval);
      logic [31:0] limit;
      logic [31:0] quotient;
      limit = {16'd0, max_bpm_cfg, 8'd0};
      if (interval == 16'd0) begin
         return limit[15:0];
      end
      quotient = BEAT_MS_Q8 / {16'd0, interval};
      return (quotient > limit) ? limit[15:0] : quotient[15:0];
   endfunction

   function automatic bit apply_tap(input logic [15:0] interval);
      logic [31:0] sum;
      if (interval > max_interval_cfg) begin
         return 1'b0;
      end
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
         tempo_hist[i-1] = tempo_hist[i];
      end
      tempo_hist[WINDOW_DEPTH-1] = tap_tempo_q8(interval);
      sum = 32'd0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         sum += {16'd0, tempo_hist[i]};
      end
      pending_bpm_q.insert(pending_bpm_q.size(), 16'(sum / WINDOW_DEPTH));
      return 1'b1;
   endfunction

   task automatic log_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("bpm_estimate %s: expected %0d actual %0d", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bpm_q.size() == 0) begin
            log_mismatch("unexpected transaction", -1, rsp_bpm_estimate);
         end else begin
            bpm_want = pending_bpm_q.pop_front();
            if (rsp_bpm_estimate !== bpm_want) begin
               log_mismatch("mismatch", bpm_want, rsp_bpm_estimate);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            hold_count = 0;
            while (hold_count < RSP_HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
            rsp_stall <= 1'b0;
            rsp_hold_req = 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tap(input logic [15:0] interval, output bit taken);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_interval_ms <= interval;
      do @(posedge clock); while (req_stall);
      taken = apply_tap(interval);
   endtask

   task automatic send_taps(input logic [15:0] intervals [$]);
      bit taken;
      foreach (intervals[i]) begin
         send_tap(intervals[i], taken);
      end
   endtask

   task automatic wait_block_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bpm_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_INTERVAL) begin
         max_interval_cfg = data;
      end else if (idx == CSR_MAX_BPM) begin
         max_bpm_cfg = data[7:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_interval();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 16'($urandom_range(0, max_interval_cfg));
      end else if (r < 72) begin
         return 16'($urandom_range(0, (max_interval_cfg < 300) ? max_interval_cfg : 300));
      end else if (r < 87 && max_interval_cfg != 16'hFFFF) begin
         return 16'($urandom_range(max_interval_cfg + 1, 65535));
      end
      return 16'($urandom);
   endfunction

   task automatic send_random_taps(input int count);
      int accepted;
      bit taken;
      accepted = 0;
      while (accepted < count) begin
         send_tap(pick_interval(), taken);
         if (taken) accepted++;
      end
   endtask

   task automatic test_reset_defaults();
      send_taps('{16'd250, 16'd251, 16'd0, 16'd1, 16'd2000, 16'd2001, 16'hFFFF,
                  16'd500, 16'd1000});
   endtask

   task automatic test_interval_limits();
      wait_block_idle();
      write_register(CSR_MAX_INTERVAL, 16'd0);
      send_taps('{16'd0, 16'd1, 16'hFFFF});
      wait_block_idle();
      write_register(CSR_MAX_INTERVAL, 16'hFFFF);
      send_taps('{16'hFFFF, 16'h8000});
   endtask

   task automatic test_bpm_clamp();
      wait_block_idle();
      write_register(CSR_MAX_BPM, 16'hFF00);
      send_taps('{16'd300, 16'd0});
      wait_block_idle();
      write_register(CSR_MAX_BPM, 16'h00FF);
      send_taps('{16'd0, 16'd60, 16'd61, 16'd250});
      wait_block_idle();
      write_register(CSR_MAX_BPM, 16'd1);
      send_taps('{16'd100});
   endtask

   task automatic test_unmapped_register();
      wait_block_idle();
      write_register(CSR_UNMAPPED_LO, 16'd0);
      write_register(CSR_UNMAPPED_HI, 16'hFFFF);
      send_taps('{16'd1, 16'd40000});
   endtask

   task automatic test_random_settings();
      logic [15:0] interval_lim;
      logic [7:0] bpm_lim;
      logic [7:0] upper_junk;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               interval_lim = MAX_INTERVAL_RST;
               bpm_lim = MAX_BPM_RST;
            end
            1: begin
               interval_lim = 16'hFFFF;
               bpm_lim = 8'hFF;
            end
            2: begin
               interval_lim = 16'd1;
               bpm_lim = 8'd1;
            end
            3: begin
               interval_lim = 16'd0;
               bpm_lim = 8'd0;
            end
            4: begin
               interval_lim = 16'($urandom_range(1, 65535));
               bpm_lim = 8'($urandom_range(1, 255));
            end
            default: begin
               interval_lim = 16'($urandom_range(200, 4000));
               bpm_lim = 8'($urandom_range(1, 255));
            end
         endcase
         upper_junk = 8'($urandom);
         wait_block_idle();
         write_register(CSR_MAX_INTERVAL, interval_lim);
         write_register(CSR_MAX_BPM, {upper_junk, bpm_lim});
         write_register(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
         send_random_taps(80);
      end
   endtask

   task automatic test_backpressure();
      bit taken;
      wait_block_idle();
      write_register(CSR_MAX_INTERVAL, 16'd3000);
      write_register(CSR_MAX_BPM, 16'd240);
      idle_enable = 1'b0;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_tap(16'($urandom_range(0, 3000)), taken);
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_no_idle_tail();
      wait_block_idle();
      idle_enable = 1'b0;
      write_register(CSR_MAX_INTERVAL, 16'd2000);
      write_register(CSR_MAX_BPM, 16'd200);
      send_random_taps(100);
   endtask

   initial begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         tempo_hist[i] = 16'd0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_interval_limits();
      test_bpm_clamp();
      test_unmapped_register();
      test_random_settings();
      test_backpressure();
      test_no_idle_tail();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bpm_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_bpm_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ttba_pkg.sv
hdl/tap_tempo_bpm_averager.sv
hdl/ttba_chk.sv
tb/testbench.sv
